// ----- hdl/gac_pkg.sv -----
// Shared types, constants and the blink period table of the gas alarm controller.
`default_nettype none

package gac_pkg;

  localparam int PPM_W    = 20;
  localparam int TICK_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [PPM_W-1:0] PPM_SAT = PPM_W'(1000000);

  localparam logic [PPM_W-1:0] LOW_RESET   = PPM_W'(10);
  localparam logic [PPM_W-1:0] MID_RESET   = PPM_W'(200);
  localparam logic [PPM_W-1:0] ALARM_RESET = PPM_W'(500);

  localparam logic [TICK_W-1:0] PERIOD_MAX = TICK_W'(1000);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM = 2'd2;

  // gas level codes
  localparam logic [1:0] LVL_CLEAN    = 2'd0;
  localparam logic [1:0] LVL_MODERATE = 2'd1;
  localparam logic [1:0] LVL_DANGER   = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RUNSTOP = 2'd3
  } op_t;

  typedef struct packed {
    op_t              opcode;
    logic [PPM_W-1:0] ppm_sample;
  } req_t;

  typedef struct packed {
    logic       led_green;
    logic       led_yellow;
    logic       led_blink;
    logic       alarm_main;
    logic       alarm_aux;
    logic       stop_led;
    logic [1:0] gas_level;
    logic       running;
    logic       warning_latched;
    logic       msg_alarm;
    logic       msg_high;
  } rsp_t;

  typedef struct packed {
    logic [PPM_W-1:0] low;
    logic [PPM_W-1:0] mid;
    logic [PPM_W-1:0] alarm;
  } cfg_t;

  typedef struct packed {
    logic stop;
    logic aux;
    logic main;
    logic blink;
    logic yellow;
    logic green;
  } pins_t;

  // blink period in ms, chosen by the peak reading
  function automatic logic [TICK_W-1:0] period_for(input logic [PPM_W-1:0] p);
    logic [TICK_W-1:0] r;
    if (p < PPM_W'(500))        r = TICK_W'(1000);
    else if (p < PPM_W'(700))   r = TICK_W'(500);
    else if (p < PPM_W'(1000))  r = TICK_W'(333);
    else if (p < PPM_W'(2000))  r = TICK_W'(250);
    else if (p < PPM_W'(5000))  r = TICK_W'(143);
    else if (p < PPM_W'(10000)) r = TICK_W'(100);
    else                        r = TICK_W'(50);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gac_core.sv -----
// Controller state and the per-beat next-state and result logic.
`default_nettype none

module gac_core import gac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t item,
  input  cfg_t cfg,
  output rsp_t result
);

  logic              running, running_next;
  logic              latch, latch_next;
  logic [PPM_W-1:0]  peak, peak_next;
  logic [PPM_W-1:0]  last, last_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [TICK_W-1:0] period, period_next;
  pins_t             pins, pins_next;

  logic [PPM_W-1:0]  p;
  logic [TICK_W-1:0] tick_inc;
  logic              m_alarm, m_high;

  always_comb begin
    p = (item.ppm_sample > PPM_SAT) ? PPM_SAT : item.ppm_sample;
    tick_inc = tick_count + TICK_W'(1);

    running_next    = running;
    latch_next      = latch;
    peak_next       = peak;
    last_next       = last;
    tick_count_next = tick_count;
    period_next     = period;
    pins_next       = pins;
    m_alarm         = 1'b0;
    m_high          = 1'b0;

    unique case (item.opcode)
      OP_SAMPLE: begin
        last_next = p;
        if (running) begin
          pins_next.stop = 1'b0;
          peak_next   = (p > peak) ? p : peak;
          period_next = period_for(peak_next);
          m_alarm     = peak_next > cfg.alarm;
          latch_next  = latch | (p >= cfg.alarm);
          m_high      = (p >= cfg.mid) && (p <= cfg.alarm);
          if (latch_next) begin
            pins_next.main   = 1'b1;
            pins_next.aux    = 1'b1;
            pins_next.green  = 1'b0;
            pins_next.yellow = 1'b0;
          end else begin
            pins_next.aux = 1'b0;
            // unlatched means p is below the alarm level here
            priority if (p < cfg.low) begin
              pins_next.green  = 1'b1;
              pins_next.yellow = 1'b0;
              pins_next.blink  = 1'b0;
              pins_next.main   = 1'b0;
            end else if (p < cfg.mid) begin
              pins_next.yellow = 1'b1;
              pins_next.green  = 1'b0;
              pins_next.blink  = 1'b0;
              pins_next.main   = 1'b0;
            end else begin
              pins_next.green  = 1'b0;
              pins_next.yellow = 1'b0;
              pins_next.main   = 1'b0;
            end
          end
        end else begin
          pins_next.stop   = 1'b1;
          pins_next.green  = 1'b0;
          pins_next.yellow = 1'b0;
          pins_next.blink  = 1'b0;
          pins_next.main   = 1'b0;
        end
      end
      OP_TICK: begin
        if (tick_inc >= period) begin
          tick_count_next = '0;
          if (running && (last >= cfg.mid || peak > cfg.alarm)) begin
            pins_next.blink = ~pins.blink;
          end else begin
            pins_next.blink = 1'b0;
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end
      OP_CLEAR: begin
        if (running) begin
          latch_next = 1'b0;
          peak_next  = '0;
        end
      end
      OP_RUNSTOP: begin
        running_next = ~running;
      end
      default: begin
      end
    endcase

    result.led_green       = pins_next.green;
    result.led_yellow      = pins_next.yellow;
    result.led_blink       = pins_next.blink;
    result.alarm_main      = pins_next.main;
    result.alarm_aux       = pins_next.aux;
    result.stop_led        = pins_next.stop;
    result.running         = running_next;
    result.warning_latched = latch_next;
    result.msg_alarm       = m_alarm;
    result.msg_high        = m_high;
    if (last_next < cfg.low)        result.gas_level = LVL_CLEAN;
    else if (last_next < cfg.alarm) result.gas_level = LVL_MODERATE;
    else                            result.gas_level = LVL_DANGER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b1;
      latch      <= 1'b0;
      peak       <= '0;
      last       <= '0;
      tick_count <= '0;
      period     <= PERIOD_MAX;
      pins       <= '0;
    end else if (fire) begin
      running    <= running_next;
      latch      <= latch_next;
      peak       <= peak_next;
      last       <= last_next;
      tick_count <= tick_count_next;
      period     <= period_next;
      pins       <= pins_next;
    end
  end

  // count restarts on reaching the period, which never exceeds the table maximum
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    tick_count < PERIOD_MAX)
    else $error("tick counter ran past the longest blink period");

  a_peak_sat: assert property (@(posedge clk) disable iff (rst)
    peak <= PPM_SAT && last <= PPM_SAT)
    else $error("stored reading above saturation");

  a_period_follows_peak: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OP_SAMPLE && running |=> period == period_for(peak))
    else $error("blink period out of step with peak");

endmodule

`default_nettype wire

// ----- hdl/gac_out_buf.sv -----
// Two-entry result stage: output register plus skid register.
`default_nettype none

module gac_out_buf import gac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  rsp_t push_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  logic skid_valid;
  rsp_t skid_data;

  assign push_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) out_data <= skid_data;
      else if (push)  out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into a full result stage");

endmodule

`default_nettype wire

// ----- hdl/gas_alarm_controller.sv -----
// Top level of the gas alarm controller: config registers, input register, core, result stage.
`default_nettype none

// Gas alarm controller. Each request beat is a ppm sample, a 1 ms tick, an
// alarm-clear press or a run/stop press, and produces exactly one response
// beat with the pin states, gas level and message flags after that item.
// Throughput is one beat per clock while the receiver takes responses; a beat
// passes the input register, then the core's next-state logic into the output
// register. The input register hands its beat on whenever the two-entry result
// stage has room, so a new request is taken while a response still waits to be
// read. The user must write thresholds on the cfg port only while no beat is in
// flight; the block itself does not enforce this. Index 0 is the low level, 1 the
// mid level, 2 the alarm level, other indexes are ignored.

module gas_alarm_controller import gac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PPM_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic q_valid;
  req_t q_item;
  logic buf_ready;
  logic advance;
  rsp_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low   <= LOW_RESET;
      cfg.mid   <= MID_RESET;
      cfg.alarm <= ALARM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOW)   cfg.low   <= cfg_data;
      if (cfg_index == REG_MID)   cfg.mid   <= cfg_data;
      if (cfg_index == REG_ALARM) cfg.alarm <= cfg_data;
    end
  end

  assign advance   = q_valid & buf_ready;
  assign req_ready = ~q_valid | buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req_ready) begin
      q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) q_item <= req;
  end

  gac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (q_item),
    .cfg    (cfg),
    .result (result)
  );

  gac_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_ready (buf_ready),
    .push_data  (result),
    .out_valid  (rsp_valid),
    .out_ready  (rsp_ready),
    .out_data   (rsp)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the gas alarm controller: directed and random beats, checked per field.
`default_nettype none

module testbench;
  import gac_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW;
  logic [PPM_W-1:0]     cfg_data = '0;

  gas_alarm_controller dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // controller state as the testbench sees it
  logic [PPM_W-1:0]  thr_low = LOW_RESET;
  logic [PPM_W-1:0]  thr_mid = MID_RESET;
  logic [PPM_W-1:0]  thr_alarm = ALARM_RESET;
  logic              is_running, warn_latch;
  logic [PPM_W-1:0]  peak_ppm_q, last_ppm_q;
  logic [TICK_W-1:0] ms_count, blink_ms;
  pins_t             pin_q;

  req_t events_to_send[$];
  rsp_t alarm_reports[$];
  rsp_t oldest_report;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic logic [TICK_W-1:0] blink_ms_for(input logic [PPM_W-1:0] p);
    if (p < 500) return TICK_W'(1000);
    if (p < 700) return TICK_W'(500);
    if (p < 1000) return TICK_W'(333);
    if (p < 2000) return TICK_W'(250);
    if (p < 5000) return TICK_W'(143);
    if (p < 10000) return TICK_W'(100);
    return TICK_W'(50);
  endfunction

  function automatic logic [1:0] classify_ppm(input logic [PPM_W-1:0] p);
    if (p < thr_low) return LVL_CLEAN;
    if (p < thr_alarm) return LVL_MODERATE;
    return LVL_DANGER;
  endfunction

  task automatic advance_alarm(input req_t item);
    logic [PPM_W-1:0] p;
    logic m_alarm, m_high;
    rsp_t r;
    m_alarm = 1'b0;
    m_high = 1'b0;
    case (item.opcode)
      OP_SAMPLE: begin
        p = item.ppm_sample;
        if (p > PPM_SAT) p = PPM_SAT;
        last_ppm_q = p;
        if (is_running) begin
          pin_q.stop = 1'b0;
          if (p > peak_ppm_q) peak_ppm_q = p;
          blink_ms = blink_ms_for(peak_ppm_q);
          m_alarm = peak_ppm_q > thr_alarm;
          if (p >= thr_alarm) warn_latch = 1'b1;
          m_high = (p >= thr_mid) && (p <= thr_alarm);
          if (warn_latch) begin
            pin_q.main = 1'b1;
            pin_q.aux = 1'b1;
            pin_q.green = 1'b0;
            pin_q.yellow = 1'b0;
          end else begin
            pin_q.aux = 1'b0;
            if (p < thr_low) begin
              pin_q.green = 1'b1;
              pin_q.yellow = 1'b0;
              pin_q.blink = 1'b0;
              pin_q.main = 1'b0;
            end else if (p < thr_mid) begin
              pin_q.yellow = 1'b1;
              pin_q.green = 1'b0;
              pin_q.blink = 1'b0;
              pin_q.main = 1'b0;
            end else if (p < thr_alarm) begin
              // blink left as it was
              pin_q.green = 1'b0;
              pin_q.yellow = 1'b0;
              pin_q.main = 1'b0;
            end
          end
        end else begin
          // stopped: aux keeps its state
          pin_q.stop = 1'b1;
          pin_q.green = 1'b0;
          pin_q.yellow = 1'b0;
          pin_q.blink = 1'b0;
          pin_q.main = 1'b0;
        end
      end
      OP_TICK: begin
        ms_count = ms_count + 1'b1;
        if (ms_count >= blink_ms) begin
          ms_count = '0;
          if (is_running && (last_ppm_q >= thr_mid || peak_ppm_q > thr_alarm))
            pin_q.blink = ~pin_q.blink;
          else
            pin_q.blink = 1'b0;
        end
      end
      OP_CLEAR: begin
        if (is_running) begin
          warn_latch = 1'b0;
          peak_ppm_q = '0;
        end
      end
      default: is_running = ~is_running;
    endcase
    r.led_green = pin_q.green;
    r.led_yellow = pin_q.yellow;
    r.led_blink = pin_q.blink;
    r.alarm_main = pin_q.main;
    r.alarm_aux = pin_q.aux;
    r.stop_led = pin_q.stop;
    r.gas_level = classify_ppm(last_ppm_q);
    r.running = is_running;
    r.warning_latched = warn_latch;
    r.msg_alarm = m_alarm;
    r.msg_high = m_high;
    alarm_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      is_running = 1'b1;
      warn_latch = 1'b0;
      peak_ppm_q = '0;
      last_ppm_q = '0;
      ms_count = '0;
      blink_ms = PERIOD_MAX;
      pin_q = '0;
    end else begin
      if (req_valid && req_ready) advance_alarm(req);
      if (!req_valid || req_ready) begin
        if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= events_to_send.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (alarm_reports.size() == 0) begin
          $display("%0t unexpected response beat: expected none, actual %h", $time, rsp);
          mismatches++;
        end else begin
          oldest_report = alarm_reports.pop_front();
          check_field("led_green", oldest_report.led_green, rsp.led_green);
          check_field("led_yellow", oldest_report.led_yellow, rsp.led_yellow);
          check_field("led_blink", oldest_report.led_blink, rsp.led_blink);
          check_field("alarm_main", oldest_report.alarm_main, rsp.alarm_main);
          check_field("alarm_aux", oldest_report.alarm_aux, rsp.alarm_aux);
          check_field("stop_led", oldest_report.stop_led, rsp.stop_led);
          check_field("gas_level", oldest_report.gas_level, rsp.gas_level);
          check_field("running", oldest_report.running, rsp.running);
          check_field("warning_latched", oldest_report.warning_latched,
                      rsp.warning_latched);
          check_field("msg_alarm", oldest_report.msg_alarm, rsp.msg_alarm);
          check_field("msg_high", oldest_report.msg_high, rsp.msg_high);
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_event(input op_t op, input logic [PPM_W-1:0] ppm);
    req_t item;
    item.opcode = op;
    item.ppm_sample = ppm;
    events_to_send.push_back(item);
  endtask

  function automatic logic [PPM_W-1:0] clamp_ppm(input longint v);
    if (v < 0) return '0;
    if (v > 64'hFFFFF) return '1;
    return PPM_W'(v);
  endfunction

  function automatic logic [PPM_W-1:0] pick_ppm();
    longint edge_ppm;
    case ($urandom_range(7))
      0: return clamp_ppm(longint'(thr_low) + $urandom_range(4) - 2);
      1: return clamp_ppm(longint'(thr_mid) + $urandom_range(4) - 2);
      2: return clamp_ppm(longint'(thr_alarm) + $urandom_range(4) - 2);
      3: begin
        case ($urandom_range(5))
          0: edge_ppm = 500;
          1: edge_ppm = 700;
          2: edge_ppm = 1000;
          3: edge_ppm = 2000;
          4: edge_ppm = 5000;
          default: edge_ppm = 10000;
        endcase
        return clamp_ppm(edge_ppm + $urandom_range(2) - 1);
      end
      4: return PPM_W'($urandom_range(20'hFFFFF, 999990));
      5: return PPM_W'($urandom);
      6: return PPM_W'($urandom_range(1000));
      default: return PPM_W'($urandom_range(20000));
    endcase
  endfunction

  // mostly samples and ticks, with tick bursts so the blink counter reaches its period
  task automatic queue_random(input int n);
    int count;
    int r;
    int burst;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        burst = $urandom_range(70, 20);
        repeat (burst) push_event(OP_TICK, PPM_W'($urandom));
        count += burst;
      end else begin
        if (r < 45) push_event(OP_SAMPLE, pick_ppm());
        else if (r < 90) push_event(OP_TICK, PPM_W'($urandom));
        else if (r < 97) push_event(OP_CLEAR, PPM_W'($urandom));
        else push_event(OP_RUNSTOP, PPM_W'($urandom));
        count++;
      end
    end
  endtask

  // wait for every beat to be sent and answered
  task automatic settle();
    @(negedge clk);
    while (events_to_send.size() != 0 || req_valid || alarm_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [PPM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LOW:   thr_low = val;
      REG_MID:   thr_mid = val;
      REG_ALARM: thr_alarm = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(input logic [PPM_W-1:0] lo, input logic [PPM_W-1:0] mi,
                            input logic [PPM_W-1:0] al);
    write_threshold(REG_LOW, lo);
    write_threshold(REG_MID, mi);
    write_threshold(REG_ALARM, al);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    logic [PPM_W-1:0] a, b, c, t;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed pass at the reset thresholds
    set_idling(0, 0);
    push_event(OP_TICK, '0);
    push_event(OP_SAMPLE, '0);
    push_event(OP_SAMPLE, 20'd9);
    push_event(OP_SAMPLE, 20'd10);
    push_event(OP_SAMPLE, 20'd199);
    push_event(OP_SAMPLE, 20'd200);
    push_event(OP_SAMPLE, 20'd499);
    push_event(OP_SAMPLE, 20'd500);
    push_event(OP_SAMPLE, 20'd501);
    push_event(OP_SAMPLE, 20'hFFFFF);     // saturates
    push_event(OP_SAMPLE, PPM_SAT);
    push_event(OP_TICK, 20'hFFFFF);
    push_event(OP_CLEAR, '0);
    push_event(OP_SAMPLE, 20'd5);
    push_event(OP_SAMPLE, 20'd300);
    push_event(OP_RUNSTOP, '0);
    push_event(OP_SAMPLE, 20'd700);        // stopped: aux kept
    push_event(OP_CLEAR, '0);              // ignored while stopped
    push_event(OP_TICK, '0);
    push_event(OP_RUNSTOP, 20'hFFFFF);
    push_event(OP_SAMPLE, 20'd300);
    push_event(OP_SAMPLE, 20'd0);
    settle();

    set_levels(20'($urandom_range(100)), 20'($urandom_range(400, 100)),
               20'($urandom_range(2000, 300)));
    queue_random(250);
    settle();

    set_levels('0, '0, '0);
    write_threshold(REG_UNUSED, 20'hFFFFF);
    set_idling(71, 0);
    queue_random(150);
    settle();

    set_levels(PPM_SAT, PPM_SAT, PPM_SAT);
    set_idling(0, 71);
    queue_random(150);
    settle();

    a = 20'($urandom_range(20000));
    b = 20'($urandom_range(20000));
    c = 20'($urandom_range(20000));
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    set_levels(a, b, c);
    set_idling(31, 31);
    queue_random(200);
    // receiver holds off while the sender keeps offering beats
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    settle();

    set_levels(20'($urandom_range(1000000)), 20'($urandom_range(1000000)),
               20'($urandom_range(1000000)));
    queue_random(120);
    settle();
    set_idling(0, 0);
    queue_random(130);
    settle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && alarm_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/gac_pkg.sv
hdl/gac_core.sv
hdl/gac_out_buf.sv
hdl/gas_alarm_controller.sv
dv/testbench.sv
